/* src/bcf_pkg.sv */
// bcf_pkg: shared constants, types and the interpolation function of the
// bezier curve flattener. No dependencies.
`timescale 1ns / 1ps

package bcf_pkg;

    localparam int COORD_WIDTH = 16;                 // integer coordinate width
    localparam int FRAC_T      = 16;                 // fraction bits of t
    localparam int QW          = COORD_WIDTH + FRAC_T;
    localparam int OUT_W       = 24;
    localparam int OUT_FRAC    = 8;
    localparam int MAX_STEPS   = 64;
    localparam int STEP_W      = 7;
    localparam int DIV_W       = FRAC_T + 2;         // width of the 2^(FRAC_T+1) dividend
    localparam int CNT_W       = $clog2(DIV_W + 1);
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(8);

    // register index, taken from paddr[2]
    localparam logic REG_STEP = 1'b0;

    // segment kinds
    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_QUAD  = 2'd1;
    localparam logic [1:0] KIND_CUBIC = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] t_crd;
    typedef logic signed [QW-1:0]          t_q16;
    typedef logic [FRAC_T-1:0]             t_frac;

    typedef struct packed {
        logic  vld;
        logic  last;
        t_frac t;
    } t_issue;

    typedef struct packed {
        logic vld;
        logic last;
    } t_pctl;

    // a + (b - a) * t / 2^FRAC_T, rounded half up, product formed exactly
    function automatic t_q16 bcf_lerp(input t_q16 a, input t_q16 b, input t_frac t);
        localparam int PW = QW + FRAC_T + 2;
        logic signed [QW:0]   d;
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] s;
        d = (QW+1)'(b) - (QW+1)'(a);
        p = PW'(d) * PW'($signed({1'b0, t}));
        s = p + (PW'(1) <<< (FRAC_T - 1));
        return a + QW'(s >>> FRAC_T);
    endfunction

endpackage

/* src/bcf_intf.sv */
// bcf_intf: valid/ready channels for control points and samples.
// Depends on bcf_pkg.
`timescale 1ns / 1ps

interface bcf_pt_if import bcf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic [1:0]                    curve_kind;
    logic                          starts_curve;

    modport source(output valid, px, py, pz, curve_kind, starts_curve, input ready);
    modport sink(input valid, px, py, pz, curve_kind, starts_curve, output ready);
endinterface

interface bcf_smp_if import bcf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic                    last_of_run;

    modport source(output valid, out_x, out_y, out_z, last_of_run, input ready);
    modport sink(input valid, out_x, out_y, out_z, last_of_run, output ready);
endinterface

/* src/bcf_tgen.sv */
// bcf_tgen: parameter sequencer. Finds 2^17 / (2*steps) with a serial divider
// after reset and step writes, then issues t = i/steps, one sample per cycle while i_adv allows.
// Depends on bcf_pkg.
`timescale 1ns / 1ps

module bcf_tgen import bcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [STEP_W-1:0] i_step,     // clamped to 1..MAX_STEPS
    input  logic              i_div_go,
    input  logic              i_start,
    input  logic              i_adv,
    output logic              o_idle,
    output t_issue            o_iss
);

    localparam logic [DIV_W-1:0] DIV_N = DIV_W'(1) << (FRAC_T + 1);

    logic [CNT_W-1:0]  r_div_cnt;
    logic [DIV_W-1:0]  r_dq;
    logic [STEP_W:0]   r_drem;
    logic              r_act;
    logic [STEP_W-1:0] r_i;
    logic [STEP_W-1:0] r_steps;
    logic [FRAC_T:0]   r_q;
    logic [STEP_W:0]   r_racc;
    logic              r_t_vld;
    logic              r_t_last;
    t_frac             r_t;

    logic [STEP_W:0]   w_dsor;
    logic [STEP_W+1:0] w_sh;
    logic              w_ge;
    logic              w_load;
    logic              w_last;
    logic [STEP_W:0]   w_d2;
    logic [STEP_W+1:0] w_r2;
    logic              w_wrap;

    assign w_dsor = {i_step, 1'b0};
    assign w_sh   = {r_drem, r_dq[DIV_W-1]};
    assign w_ge   = w_sh >= {1'b0, w_dsor};

    assign w_load = r_act && (!r_t_vld || i_adv);
    assign w_last = r_i == (r_steps - STEP_W'(1));
    assign w_d2   = {r_steps, 1'b0};
    // remainder of the running quotient steps by R and wraps at most once
    assign w_r2   = {1'b0, r_racc} + {1'b0, r_drem};
    assign w_wrap = w_r2 >= {1'b0, w_d2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= CNT_W'(DIV_W);
            r_dq      <= DIV_N;
            r_drem    <= '0;
        end else if (i_div_go) begin
            r_div_cnt <= CNT_W'(DIV_W);
            r_dq      <= DIV_N;
            r_drem    <= '0;
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - CNT_W'(1);
            r_dq      <= {r_dq[DIV_W-2:0], w_ge};
            r_drem    <= w_ge ? STEP_W'(w_sh - {1'b0, w_dsor}) + (STEP_W+1)'(0)
                              : w_sh[STEP_W:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_t_vld <= 1'b0;
        end else begin
            if (i_start) begin
                r_act <= 1'b1;
            end else if (w_load && w_last) begin
                r_act <= 1'b0;
            end
            if (w_load) begin
                r_t_vld <= 1'b1;
            end else if (i_adv) begin
                r_t_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i     <= '0;
            r_q     <= '0;
            r_racc  <= {1'b0, i_step};
            r_steps <= i_step;
        end else if (w_load) begin
            r_i    <= r_i + STEP_W'(1);
            r_q    <= r_q + r_dq[FRAC_T:0] + (FRAC_T+1)'(w_wrap);
            r_racc <= w_wrap ? (STEP_W+1)'(w_r2 - {1'b0, w_d2}) : w_r2[STEP_W:0];
        end
        if (w_load) begin
            r_t      <= r_q[FRAC_T-1:0];
            r_t_last <= w_last;
        end
    end

    assign o_idle = (r_div_cnt == '0) && !r_act && !r_t_vld;
    assign o_iss  = '{vld: r_t_vld, last: r_t_last, t: r_t};

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_i < r_steps))
        else $error("sample index past step count");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_racc < w_d2))
        else $error("t remainder out of range");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && o_idle) |=> (r_act && (r_i == '0) && (r_q == '0)))
        else $error("run did not start at t zero");
`endif

endmodule

/* src/bcf_lane.sv */
// bcf_lane: three-level de Casteljau pipeline for one coordinate, with bypass
// of the upper levels for lines and quadratics. Depends on bcf_pkg.
`timescale 1ns / 1ps

module bcf_lane import bcf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_adv,
    input  t_crd       i_p [4],
    input  logic [1:0] i_kind,
    input  t_frac      i_t,
    output t_q16       o_q
);

    t_q16       w_p [4];
    t_q16       r_s [3];
    t_q16       r_u [2];
    t_q16       r_f;
    logic [1:0] r_k1;
    logic [1:0] r_k2;
    t_frac      r_t1;
    t_frac      r_t2;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_p[k] = {i_p[k], {FRAC_T{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= bcf_lerp(w_p[k], w_p[k+1], i_t);
            end
            r_k1 <= i_kind;
            r_t1 <= i_t;

            r_u[0] <= (r_k1 == KIND_LINE) ? r_s[0] : bcf_lerp(r_s[0], r_s[1], r_t1);
            r_u[1] <= bcf_lerp(r_s[1], r_s[2], r_t1);
            r_k2   <= r_k1;
            r_t2   <= r_t1;

            r_f <= (r_k2 == KIND_CUBIC) ? bcf_lerp(r_u[0], r_u[1], r_t2) : r_u[0];
        end
    end

    assign o_q = r_f;

endmodule

/* src/bcf_merge.sv */
// bcf_merge: joins the three lanes into one sample, rounds to Q8, saturates,
// and holds the output register. Depends on bcf_pkg and bcf_intf.
`timescale 1ns / 1ps

module bcf_merge import bcf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_q16         i_q [3],
    input  t_pctl        i_ctl,
    output logic         o_adv,
    bcf_smp_if.source    o_smp
);

    localparam logic signed [63:0] SAT_HI = 64'sd8388607;
    localparam logic signed [63:0] SAT_LO = -64'sd8388608;

    function automatic logic signed [OUT_W-1:0] to_out(input t_q16 v);
        logic signed [QW:0]   r;
        logic signed [63:0]   q;
        r = (QW+1)'(v) + (QW+1)'(1 << (OUT_FRAC - 1));
        q = 64'(r >>> (FRAC_T - OUT_FRAC));
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[OUT_W-1:0];
    endfunction

    logic                    r_vld;
    logic                    r_last;
    logic signed [OUT_W-1:0] r_x;
    logic signed [OUT_W-1:0] r_y;
    logic signed [OUT_W-1:0] r_z;

    assign o_adv = !r_vld || o_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_x    <= to_out(i_q[0]);
            r_y    <= to_out(i_q[1]);
            r_z    <= to_out(i_q[2]);
            r_last <= i_ctl.last;
        end
    end

    assign o_smp.valid       = r_vld;
    assign o_smp.out_x       = r_x;
    assign o_smp.out_y       = r_y;
    assign o_smp.out_z       = r_z;
    assign o_smp.last_of_run = r_last;

endmodule

/* src/bezier_curve_flattener_top.sv */
// bezier_curve_flattener_top: control point store, step register, lanes and merge.
// Depends on bcf_pkg, bcf_intf, bcf_tgen, bcf_lane and bcf_merge.
//
//   channel   dir  handshake          payload
//   i_pt      in   valid / ready      px py pz curve_kind starts_curve
//   o_smp     out  valid / ready      out_x out_y out_z last_of_run
//   apb       in   psel penable       paddr pwdata -> prdata, step_count at 0x0
//
// A closing point starts a run of steps samples, one per cycle from the t sequencer
// while the output is not stalled; the first sample passes through the t register,
// the three lane levels and the merge output register. The next point is taken
// once the last sample has left the sequencer.
// After reset and after each step_count write the t divider runs with the point
// request held off. A stalled sample request freezes the whole lane pipeline.
`timescale 1ns / 1ps

module bezier_curve_flattener_top import bcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bcf_pt_if.sink            i_pt,
    bcf_smp_if.source         o_smp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] w_step_eff;
    logic              w_wr;

    t_crd       r_sx [4];
    t_crd       r_sy [4];
    t_crd       r_sz [4];
    logic [2:0] r_held;
    logic [1:0] r_kind;

    logic       w_acc;
    logic       w_close;
    logic       w_idle;
    logic       w_adv;
    t_issue     w_iss;
    t_pctl      r_c1;
    t_pctl      r_c2;
    t_pctl      r_c3;
    t_q16       w_q [3];

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_STEP);
    assign prdata = (paddr[2] == REG_STEP) ? {(APB_DW-STEP_W)'(0), r_step} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (w_wr) begin
            r_step <= pwdata[STEP_W-1:0];
        end
    end

    always_comb begin
        if (r_step == '0) begin
            w_step_eff = STEP_W'(1);
        end else if (r_step > STEP_W'(MAX_STEPS)) begin
            w_step_eff = STEP_W'(MAX_STEPS);
        end else begin
            w_step_eff = r_step;
        end
    end

    // point request handling
    assign i_pt.ready = w_idle;
    assign w_acc      = i_pt.valid && w_idle;
    assign w_close    = w_acc && !i_pt.starts_curve && (r_held != '0)
                        && ((r_held + 3'd1) >= ({1'b0, r_kind} + 3'd2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_kind <= KIND_LINE;
        end else if (w_acc) begin
            if (i_pt.starts_curve) begin
                if (i_pt.curve_kind == KIND_BAD) begin
                    r_held <= '0;
                end else begin
                    r_held <= 3'd1;
                    r_kind <= i_pt.curve_kind;
                end
            end else if (r_held != '0) begin
                r_held <= w_close ? 3'd0 : r_held + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (i_pt.starts_curve && (i_pt.curve_kind != KIND_BAD)) begin
                r_sx[0] <= i_pt.px;
                r_sy[0] <= i_pt.py;
                r_sz[0] <= i_pt.pz;
            end else if (!i_pt.starts_curve && (r_held != '0)) begin
                r_sx[r_held[1:0]] <= i_pt.px;
                r_sy[r_held[1:0]] <= i_pt.py;
                r_sz[r_held[1:0]] <= i_pt.pz;
            end
        end
    end

    bcf_tgen u_tgen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step_eff),
        .i_div_go (w_wr),
        .i_start  (w_close),
        .i_adv    (w_adv),
        .o_idle   (w_idle),
        .o_iss    (w_iss)
    );

    // valid and last travel beside the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else if (w_adv) begin
            r_c1 <= '{vld: w_iss.vld, last: w_iss.last};
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
    end

    bcf_lane u_lane_x (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_p    (r_sx),
        .i_kind (r_kind),
        .i_t    (w_iss.t),
        .o_q    (w_q[0])
    );

    bcf_lane u_lane_y (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_p    (r_sy),
        .i_kind (r_kind),
        .i_t    (w_iss.t),
        .o_q    (w_q[1])
    );

    bcf_lane u_lane_z (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_p    (r_sz),
        .i_kind (r_kind),
        .i_t    (w_iss.t),
        .o_q    (w_q[2])
    );

    bcf_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .i_ctl   (r_c3),
        .o_adv   (w_adv),
        .o_smp   (o_smp)
    );

endmodule

/* test/bezier_curve_flattener_top_tb.sv */
// bezier_curve_flattener_top_tb: self-checking bench for the bezier curve flattener.
// Drives control points and step_count writes, predicts every sample and checks it.
// Depends on bcf_pkg, bcf_intf and bezier_curve_flattener_top.
`timescale 1ns / 1ps

module bezier_curve_flattener_top_tb;
    import bcf_pkg::*;

    localparam logic [APB_AW-1:0] STEP_ADDR  = {REG_STEP, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_STEP, 2'b00};
    localparam t_crd CRD_MIN        = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_crd CRD_MAX        = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam longint SAMPLE_HI    = longint'(2**(OUT_W-1)) - 1;
    localparam longint SAMPLE_LO    = -longint'(2**(OUT_W-1));
    localparam int IDLE_MAX         = 11;
    localparam int SETTLE_CYCLES    = 32;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int HOLD_CYCLES      = 400;
    localparam int RAND_ITEMS       = 200;
    localparam int RAND_PHASES      = 5;
    localparam int MAX_REPORTS      = 50;
    localparam longint TIMEOUT_NS   = 2_000_000;

    typedef struct {
        t_crd       x;
        t_crd       y;
        t_crd       z;
        logic [1:0] kind;
        logic       start;
    } t_point;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    last;
    } t_sample;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bcf_pt_if  pt_if();
    bcf_smp_if smp_if();

    bezier_curve_flattener_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_smp   (smp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // flattener state as the bench sees it
    longint           ctl_pts [4][3];
    int unsigned      pts_held;
    logic [1:0]       seg_kind;
    logic [STEP_W-1:0] step_cfg;

    t_sample sample_q[$];
    int      err_count   = 0;
    int      tx_idle_max = 0;
    int      rx_idle_max = 0;
    int      rx_gap      = 0;
    bit      rx_hold     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic t_point make_point(input t_crd x, input t_crd y, input t_crd z,
                                          input logic [1:0] kind, input logic start);
        t_point p;
        p.x     = x;
        p.y     = y;
        p.z     = z;
        p.kind  = kind;
        p.start = start;
        return p;
    endfunction

    function automatic t_crd rand_crd();
        case ($urandom_range(0, 7))
            0: begin
                return CRD_MIN;
            end
            1: begin
                return CRD_MAX;
            end
            2: begin
                return t_crd'(int'($urandom_range(0, 8)) - 4);
            end
            default: begin
                return t_crd'($urandom);
            end
        endcase
    endfunction

    // a + (b - a) * t in Q16, rounded half up
    function automatic longint blend_q16(input longint a, input longint b, input longint t);
        return a + (((b - a) * t + (longint'(1) <<< (FRAC_T - 1))) >>> FRAC_T);
    endfunction

    function automatic logic signed [OUT_W-1:0] q16_to_sample(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (FRAC_T - OUT_FRAC - 1))) >>> (FRAC_T - OUT_FRAC);
        if (r > SAMPLE_HI) r = SAMPLE_HI;
        if (r < SAMPLE_LO) r = SAMPLE_LO;
        return OUT_W'(r);
    endfunction

    // store one accepted point and queue the samples of a closed segment
    function automatic void flatten_point(input t_point p);
        longint      crd [3];
        longint      w [4];
        int unsigned need;
        int unsigned steps;
        int unsigned t;
        t_sample     smp;
        crd[0] = p.x;
        crd[1] = p.y;
        crd[2] = p.z;
        if (p.start) begin
            pts_held = 0;
            if (p.kind == KIND_BAD) return;
            seg_kind = p.kind;
        end else if (pts_held == 0) begin
            return;
        end
        for (int c = 0; c < 3; c++) ctl_pts[pts_held][c] = crd[c];
        pts_held++;
        need = int'(seg_kind) + 2;
        if (pts_held < need) return;
        pts_held = 0;
        steps = step_cfg;
        if (steps < 1) steps = 1;
        if (steps > MAX_STEPS) steps = MAX_STEPS;
        for (int unsigned i = 0; i < steps; i++) begin
            t = (i * (1 << (FRAC_T + 1)) + steps) / (2 * steps);
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < need; k++) w[k] = ctl_pts[k][c] <<< FRAC_T;
                for (int n = need - 1; n > 0; n--) begin
                    for (int k = 0; k < n; k++) w[k] = blend_q16(w[k], w[k+1], longint'(t));
                end
                case (c)
                    0: smp.x = q16_to_sample(w[0]);
                    1: smp.y = q16_to_sample(w[0]);
                    default: smp.z = q16_to_sample(w[0]);
                endcase
            end
            smp.last = (i + 1 == steps);
            sample_q.insert(sample_q.size(), smp);
        end
    endfunction

    // sample receiver: random gaps per sample, or a long hold
    initial begin
        smp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                smp_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                smp_if.ready <= 1'b0;
                rx_gap = rx_gap - 1;
            end else begin
                smp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            rx_gap = $urandom_range(0, rx_idle_max);
            if (sample_q.size() == 0) begin
                report_mismatch($sformatf("unexpected sample x=%0d y=%0d z=%0d last=%0b",
                                          smp_if.out_x, smp_if.out_y, smp_if.out_z,
                                          smp_if.last_of_run));
            end else begin
                want = sample_q.pop_front();
                if (smp_if.out_x !== want.x)
                    report_mismatch($sformatf("out_x got %0d want %0d", smp_if.out_x, want.x));
                if (smp_if.out_y !== want.y)
                    report_mismatch($sformatf("out_y got %0d want %0d", smp_if.out_y, want.y));
                if (smp_if.out_z !== want.z)
                    report_mismatch($sformatf("out_z got %0d want %0d", smp_if.out_z, want.z));
                if (smp_if.last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run got %0b want %0b",
                                              smp_if.last_of_run, want.last));
            end
        end
    end

    task automatic send_point(input t_point p);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            @(negedge i_clk);
            pt_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pt_if.valid        <= 1'b1;
        pt_if.px           <= p.x;
        pt_if.py           <= p.y;
        pt_if.pz           <= p.z;
        pt_if.curve_kind   <= p.kind;
        pt_if.starts_curve <= p.start;
        do @(posedge i_clk); while (!pt_if.ready);
        flatten_point(p);
    endtask

    // stop offering points and let every expected sample drain
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        pt_if.valid <= 1'b0;
        while (sample_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sample_q.size() != 0) begin
            report_mismatch($sformatf("%0d samples never arrived", sample_q.size()));
            sample_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_STEP) step_cfg = data[STEP_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_line(input t_crd a, input t_crd b);
        send_point(make_point(a, b, a, KIND_LINE, 1'b1));
        send_point(make_point(b, a, b, KIND_BAD, 1'b0));
    endtask

    // step_count still at its reset value, one segment of each kind
    task automatic test_reset_shapes();
        tx_idle_max = 0;
        rx_idle_max = 0;
        send_point(make_point(CRD_MIN, CRD_MIN, CRD_MIN, KIND_LINE, 1'b1));
        send_point(make_point(CRD_MAX, CRD_MAX, CRD_MAX, KIND_LINE, 1'b0));
        send_point(make_point(CRD_MAX, CRD_MIN, 0, KIND_QUAD, 1'b1));
        send_point(make_point(CRD_MIN, CRD_MAX, 1, KIND_QUAD, 1'b0));
        send_point(make_point(CRD_MAX, CRD_MAX, -1, KIND_QUAD, 1'b0));
        send_point(make_point(CRD_MIN, CRD_MAX, CRD_MIN, KIND_CUBIC, 1'b1));
        send_point(make_point(CRD_MAX, CRD_MIN, CRD_MAX, KIND_CUBIC, 1'b0));
        send_point(make_point(CRD_MIN, CRD_MAX, CRD_MIN, KIND_CUBIC, 1'b0));
        send_point(make_point(CRD_MAX, CRD_MIN, CRD_MAX, KIND_CUBIC, 1'b0));
        wait_idle();
    endtask

    task automatic test_special_points();
        tx_idle_max = IDLE_MAX;
        rx_idle_max = IDLE_MAX;
        // bad kind opens nothing, so the next point is dropped as well
        send_point(make_point(100, 200, 300, KIND_BAD, 1'b1));
        send_point(make_point(-5, -6, -7, KIND_LINE, 1'b0));
        // restart in the middle of a cubic
        send_point(make_point(10, 20, 30, KIND_CUBIC, 1'b1));
        send_point(make_point(-10, 40, 7, KIND_CUBIC, 1'b0));
        send_point(make_point(-300, 17, 1000, KIND_LINE, 1'b1));
        send_point(make_point(299, -18, -999, KIND_CUBIC, 1'b0));
        wait_idle();
    endtask

    task automatic test_step_register();
        tx_idle_max = IDLE_MAX;
        rx_idle_max = 0;
        write_reg(STEP_ADDR, '0);
        send_line(CRD_MIN, CRD_MAX);
        wait_idle();
        write_reg(STEP_ADDR, APB_DW'(2**STEP_W - 1));
        send_line(CRD_MAX, CRD_MIN);
        wait_idle();
        // unmapped address, step_count must keep its value
        write_reg(SPARE_ADDR, APB_DW'(5));
        send_line(-1234, 4321);
        wait_idle();
        write_reg(STEP_ADDR, 32'hFFFF_FF81);
        send_point(make_point(CRD_MIN, 0, CRD_MAX, KIND_QUAD, 1'b1));
        send_point(make_point(CRD_MAX, CRD_MIN, 0, KIND_QUAD, 1'b0));
        send_point(make_point(0, CRD_MAX, CRD_MIN, KIND_QUAD, 1'b0));
        wait_idle();
    endtask

    task automatic test_output_stall();
        tx_idle_max = 0;
        rx_idle_max = 3;
        write_reg(STEP_ADDR, APB_DW'(16));
        fork
            begin
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                for (int n = 0; n < 10; n++) send_line(rand_crd(), rand_crd());
            end
        join
        wait_idle();
    endtask

    task automatic test_random_segments();
        int         tx_idle [RAND_PHASES] = '{IDLE_MAX, 0, IDLE_MAX, 0, IDLE_MAX};
        int         rx_idle [RAND_PHASES] = '{IDLE_MAX, IDLE_MAX, 0, 0, IDLE_MAX};
        int         sent;
        int         npts;
        int         steps;
        logic [1:0] kind;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: steps = 3;
                1: steps = $urandom_range(1, 16);
                2: steps = MAX_STEPS;
                3: steps = $urandom_range(1, 8);
                default: steps = $urandom_range(0, 2**STEP_W - 1);
            endcase
            write_reg(STEP_ADDR, APB_DW'(steps));
            tx_idle_max = tx_idle[ph];
            rx_idle_max = rx_idle[ph];
            sent = 0;
            while (sent < RAND_ITEMS / RAND_PHASES) begin
                if ($urandom_range(0, 9) < 8) begin
                    kind = 2'($urandom_range(0, 2));
                    npts = int'(kind) + 2;
                    // now and then cut the segment short
                    if ($urandom_range(0, 9) == 0) npts = $urandom_range(1, int'(kind) + 1);
                    for (int k = 0; k < npts; k++) begin
                        send_point(make_point(rand_crd(), rand_crd(), rand_crd(),
                                              (k == 0) ? kind : 2'($urandom), k == 0));
                        sent++;
                    end
                end else begin
                    send_point(make_point(rand_crd(), rand_crd(), rand_crd(),
                                          2'($urandom), 1'($urandom)));
                    sent++;
                end
            end
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pt_if.valid        = 1'b0;
        pt_if.px           = '0;
        pt_if.py           = '0;
        pt_if.pz           = '0;
        pt_if.curve_kind   = KIND_LINE;
        pt_if.starts_curve = 1'b0;
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 3; c++) ctl_pts[k][c] = 0;
        end
        pts_held = 0;
        seg_kind = KIND_LINE;
        step_cfg = STEP_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_shapes();
        test_special_points();
        test_step_register();
        test_output_stall();
        test_random_segments();

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
